// File: rtl/pidc_pkg.sv
// Shared types and constants for the PI deadband/clamp controller.
// No dependencies; imported by the register file, the top level and the checker.
package pidc_pkg;

    localparam int DataW  = 16;               // amplitudes, gains, limits (Q4.12)
    localparam int FracW  = 12;               // fractional bits
    localparam int ErrW   = DataW + 1;        // signed error, Q5.12
    localparam int IntW   = DataW + 2;        // signed integral, Q6.12
    localparam int PropW  = DataW + 1 + ErrW; // prop product width
    localparam int IprodW = DataW + 1 + IntW; // integral product width
    localparam int AccW   = IprodW + 1;       // sum of both products
    localparam int AddrW  = 5;                // six registers at 4-byte spacing
    localparam int ApbW   = 32;

    typedef enum logic [2:0] {
        REG_TARGET_LEVEL = 3'd0,
        REG_PROP_GAIN    = 3'd1,
        REG_INTEG_GAIN   = 3'd2,
        REG_DEAD_BAND    = 3'd3,
        REG_INTEG_LIMIT  = 3'd4,
        REG_DRIVE_MAX    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [DataW-1:0] target_level;
        logic [DataW-1:0] prop_gain;
        logic [DataW-1:0] integ_gain;
        logic [DataW-1:0] dead_band;
        logic [DataW-1:0] integ_limit;
        logic [DataW-1:0] drive_max;
    } cfg_t;

    localparam logic [DataW-1:0] RstTargetLevel = 16'd9011;
    localparam logic [DataW-1:0] RstPropGain    = 16'd614;
    localparam logic [DataW-1:0] RstIntegGain   = 16'd205;
    localparam logic [DataW-1:0] RstDeadBand    = 16'd41;
    localparam logic [DataW-1:0] RstIntegLimit  = 16'd40960;
    localparam logic [DataW-1:0] RstDriveMax    = 16'd12288;

endpackage

// File: rtl/pidc_regs.sv
// APB configuration registers for the PI controller.
// Depends on pidc_pkg for the register map and the cfg_t struct.
module pidc_regs
    import pidc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [ApbW-1:0]  pwdata,
    output logic [ApbW-1:0]  prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    reg_idx_t         idx;
    logic             wr_en;
    logic [DataW-1:0] wval;
    logic [DataW-1:0] rval;

    // byte lanes below the word offset are ignored
    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign wval   = pwdata[DataW-1:0];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_TARGET_LEVEL: cfg_next.target_level = wval;
                REG_PROP_GAIN:    cfg_next.prop_gain    = wval;
                REG_INTEG_GAIN:   cfg_next.integ_gain   = wval;
                REG_DEAD_BAND:    cfg_next.dead_band    = wval;
                REG_INTEG_LIMIT:  cfg_next.integ_limit  = wval;
                REG_DRIVE_MAX:    cfg_next.drive_max    = wval;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TARGET_LEVEL: rval = cfg_reg.target_level;
            REG_PROP_GAIN:    rval = cfg_reg.prop_gain;
            REG_INTEG_GAIN:   rval = cfg_reg.integ_gain;
            REG_DEAD_BAND:    rval = cfg_reg.dead_band;
            REG_INTEG_LIMIT:  rval = cfg_reg.integ_limit;
            REG_DRIVE_MAX:    rval = cfg_reg.drive_max;
            default:          rval = '0;
        endcase
    end

    assign prdata = {{(ApbW-DataW){1'b0}}, rval};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_level <= RstTargetLevel;
            cfg_reg.prop_gain    <= RstPropGain;
            cfg_reg.integ_gain   <= RstIntegGain;
            cfg_reg.dead_band    <= RstDeadBand;
            cfg_reg.integ_limit  <= RstIntegLimit;
            cfg_reg.drive_max    <= RstDriveMax;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/pi_controller_deadband_clamp_unit.sv
// Top level of the PI controller with integration deadband and anti-windup clamp.
// Depends on pidc_pkg and pidc_regs.
// Pipeline: input reg -> integral/error reg -> product reg -> result reg.
// Throughput: one beat per cycle while m_tready holds; each stage holds one beat, four in flight.
// The integral register is the only loop: one add and clamp per cycle, when a beat advances into stage 1.
// Reset: valids and integral cleared, registers to their defaults.
module pi_controller_deadband_clamp_unit
    import pidc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // APB configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [ApbW-1:0]  pwdata,
    output logic [ApbW-1:0]  prdata,
    output logic             pready,
    // sample stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [DataW-1:0] s_tdata,   // [15:0] sample_level
    // drive stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [DataW-1:0] m_tdata,   // [15:0] drive_level
    output logic             m_tuser    // [0] drive_clamped
);

    cfg_t cfg;

    pidc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage valids and per-stage flow
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic s0_free, s1_free, s2_free, out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s2_free  = !s2_valid_reg  || out_free;
    assign s1_free  = !s1_valid_reg  || s2_free;
    assign s0_free  = !s0_valid_reg  || s1_free;
    assign s_tready = s0_free;

    // stage 0: input register
    logic [DataW-1:0] sample_reg;

    // stage 1: error and integral update
    logic signed [ErrW-1:0] err;
    logic        [ErrW-1:0] err_mag;
    logic signed [IntW-1:0] integ_sum_reg;
    logic signed [IntW-1:0] integ_sum_next;
    logic signed [IntW-1:0] integ_raw;
    logic signed [IntW-1:0] lim_pos;
    logic signed [IntW-1:0] lim_neg;
    logic signed [ErrW-1:0] err_reg;
    logic signed [IntW-1:0] integ_s1_reg;

    assign err     = $signed({1'b0, cfg.target_level}) - $signed({1'b0, sample_reg});
    assign err_mag = err[ErrW-1] ? ErrW'(-err) : err;
    assign lim_pos = $signed({2'b00, cfg.integ_limit});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        integ_raw = integ_sum_reg;
        // strictly greater: an error on the deadband edge does not integrate
        if (err_mag > {1'b0, cfg.dead_band})
        begin
            integ_raw = integ_sum_reg + IntW'(err);
        end
        // clamp applies on every beat, so a lowered limit takes effect at once
        if (integ_raw > lim_pos)
        begin
            integ_sum_next = lim_pos;
        end
        else if (integ_raw < lim_neg)
        begin
            integ_sum_next = lim_neg;
        end
        else
        begin
            integ_sum_next = integ_raw;
        end
    end

    // stage 2: products
    logic signed [PropW-1:0]  prop_prod;
    logic signed [IprodW-1:0] integ_prod;
    logic signed [PropW-1:0]  prop_prod_reg;
    logic signed [IprodW-1:0] integ_prod_reg;

    assign prop_prod  = $signed({1'b0, cfg.prop_gain}) * err_reg;
    assign integ_prod = $signed({1'b0, cfg.integ_gain}) * integ_s1_reg;

    // stage 3: sum, shift, output clamp
    logic signed [AccW-1:0]       acc;
    logic        [AccW-FracW-2:0] acc_shr;
    logic        [DataW-1:0]      drive_next;
    logic                         clamped_next;
    logic        [DataW-1:0]      drive_reg;
    logic                         clamped_reg;

    assign acc     = AccW'(prop_prod_reg) + AccW'(integ_prod_reg);
    assign acc_shr = acc[AccW-2:FracW];

    always_comb
    begin
        if (acc[AccW-1])
        begin
            drive_next   = '0;
            clamped_next = 1'b1;
        end
        else if (acc_shr > (AccW-FracW-1)'(cfg.drive_max))
        begin
            drive_next   = cfg.drive_max;
            clamped_next = 1'b1;
        end
        else
        begin
            drive_next   = acc_shr[DataW-1:0];
            clamped_next = 1'b0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            integ_sum_reg <= '0;
        end
        else
        begin
            if (s0_free)
            begin
                s0_valid_reg <= s_tvalid;
            end
            if (s1_free)
            begin
                s1_valid_reg <= s0_valid_reg;
                if (s0_valid_reg)
                begin
                    integ_sum_reg <= integ_sum_next;
                end
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s0_free && s_tvalid)
        begin
            sample_reg <= s_tdata;
        end
        if (s1_free && s0_valid_reg)
        begin
            err_reg      <= err;
            integ_s1_reg <= integ_sum_next;
        end
        if (s2_free && s1_valid_reg)
        begin
            prop_prod_reg  <= prop_prod;
            integ_prod_reg <= integ_prod;
        end
        if (out_free && s2_valid_reg)
        begin
            drive_reg   <= drive_next;
            clamped_reg <= clamped_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = clamped_reg;

endmodule

// File: rtl/pidc_checker.sv
// Port-level checks for the PI controller top level, attached by bind.
// Depends on pidc_pkg for field widths.
module pidc_checker
    import pidc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [DataW-1:0] m_tdata,
    input logic             m_tuser
);

    localparam int Depth = 4;

    logic       in_beat;
    logic       out_beat;
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_beat && !out_beat)
        begin
            inflight_next = inflight_reg + 3'd1;
        end
        else if (out_beat && !in_beat)
        begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // no result pending while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // a result appearing after an empty cycle must trace back to an accepted input beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
        else $error("result appeared without matching input latency");

    // input only backs up once every stage holds a beat
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> inflight_reg == 3'(Depth))
        else $error("input stalled with free pipeline slots");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind pi_controller_deadband_clamp_unit pidc_checker u_pidc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
